// ===== rtl/tsm_pkg.sv =====
package tsm_pkg;

	localparam int TRIG_MAX = 16;
	localparam int CHAR_W   = 8;
	localparam int SLOT_W   = 4;
	localparam int POS_W    = 4;
	localparam int LEN_W    = 5;
	localparam int CODE_W   = 16;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_REC   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MATCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WCHR  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_WLEN  = 2'd3;

	typedef struct packed {
		logic              chr_en;
		logic              len_en;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  pos;
		logic [CHAR_W-1:0] chr;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} tbl_wr_t;

	typedef struct packed {
		logic              idle;
		logic              done;
		logic              matched;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
	} seq_stat_t;

endpackage

// ===== rtl/tsm_if.sv =====
interface tsm_item_if;
	import tsm_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [CHAR_W-1:0] char_code;
	logic [SLOT_W-1:0] slot;
	logic [POS_W-1:0]  char_pos;
	logic [LEN_W-1:0]  entry_length;
	logic [CODE_W-1:0] new_end_code;

	modport source (output valid, req_type, char_code, slot, char_pos, entry_length,
		new_end_code, input ready);
	modport sink (input valid, req_type, char_code, slot, char_pos, entry_length,
		new_end_code, output ready);
endinterface

interface tsm_res_if;
	import tsm_pkg::*;

	logic              valid;
	logic              ready;
	logic              matched;
	logic [SLOT_W-1:0] matched_slot;
	logic [LEN_W-1:0]  trigger_length;
	logic [CODE_W-1:0] end_key;

	modport source (output valid, matched, matched_slot, trigger_length, end_key,
		input ready);
	modport sink (input valid, matched, matched_slot, trigger_length, end_key,
		output ready);
endinterface

interface tsm_cfg_if;
	import tsm_pkg::*;

	logic             valid;
	logic             ready;
	logic [LEN_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== rtl/typed_suffix_trigger_matcher.sv =====
// record and table write transactions leave the block idle, so the next one is taken in the following cycle
// match transaction: scans each suffix length from the longest down over the entries in use, and
//   fetches then compares each character of a candidate; one 8-bit comparator fed by registered reads
// result is returned through an output register, loaded in the done state once that register is free
// reset: history empty, all entry lengths zero, entries_in_use zero; stored characters
//   are undefined until written and get no clearing pass
module typed_suffix_trigger_matcher #(
	parameter int HISTORY_DEPTH = 16,
	parameter int TABLE_ENTRIES = 16
) (
	input logic        clk,
	input logic        arst_n,
	tsm_item_if.sink   item,
	tsm_res_if.source  result,
	tsm_cfg_if.sink    cfg
);
	import tsm_pkg::*;

	localparam int NUM_SLOTS = (TABLE_ENTRIES < 2**SLOT_W) ? TABLE_ENTRIES : 2**SLOT_W;
	localparam int HW  = $clog2(HISTORY_DEPTH);
	localparam int CW  = $clog2(HISTORY_DEPTH + 1);
	localparam int ECW = $clog2(NUM_SLOTS + 1);

	logic [LEN_W-1:0]  entries_q;
	logic [ECW-1:0]    n;
	logic              accept;
	logic              slot_ok;
	logic              rec_en;
	logic              start;
	logic              take;
	logic              clr;
	tbl_wr_t           tbl_wr;
	seq_stat_t         stat;
	logic [HW-1:0]     head;
	logic [CW-1:0]     hist_count;
	logic [HW-1:0]     hist_addr;
	logic [CHAR_W-1:0] hist_rd;
	logic [CHAR_W-1:0] trig_rd;
	logic [SLOT_W-1:0] rd_slot;
	logic [POS_W-1:0]  rd_pos;
	logic [LEN_W-1:0]  ent_len;
	logic [CODE_W-1:0] ent_code;
	logic              out_valid_q;
	logic              matched_q;
	logic [SLOT_W-1:0] slot_q;
	logic [LEN_W-1:0]  len_q;
	logic [CODE_W-1:0] code_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg.valid) begin
			entries_q <= cfg.data;
		end
	end

	assign n = (32'(entries_q) > NUM_SLOTS) ? ECW'(NUM_SLOTS) : ECW'(entries_q);

	assign item.ready = stat.idle;
	assign accept     = item.valid && item.ready;
	assign slot_ok    = (32'(item.slot) < NUM_SLOTS);
	assign rec_en     = accept && (item.req_type == REQ_REC) && (item.char_code != '0);
	assign start      = accept && (item.req_type == REQ_MATCH);

	assign tbl_wr.chr_en = accept && (item.req_type == REQ_WCHR) && slot_ok;
	assign tbl_wr.len_en = accept && (item.req_type == REQ_WLEN) && slot_ok;
	assign tbl_wr.slot   = item.slot;
	assign tbl_wr.pos    = item.char_pos;
	assign tbl_wr.chr    = item.char_code;
	assign tbl_wr.len    = item.entry_length;
	assign tbl_wr.code   = item.new_end_code;

	assign take = stat.done && (!out_valid_q || result.ready);
	assign clr  = take && stat.matched;

	tsm_hist #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_en),
		.wr_char (item.char_code),
		.clr     (clr),
		.rd_addr (hist_addr),
		.head    (head),
		.count   (hist_count),
		.rd_data (hist_rd)
	);

	tsm_tbl #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (tbl_wr),
		.rd_slot  (rd_slot),
		.rd_pos   (rd_pos),
		.chr_rd   (trig_rd),
		.ent_len  (ent_len),
		.ent_code (ent_code)
	);

	tsm_seq #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.NUM_SLOTS(NUM_SLOTS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.take      (take),
		.n         (n),
		.count     (hist_count),
		.head      (head),
		.hist_rd   (hist_rd),
		.trig_rd   (trig_rd),
		.ent_len   (ent_len),
		.hist_addr (hist_addr),
		.rd_slot   (rd_slot),
		.rd_pos    (rd_pos),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			matched_q <= stat.matched;
			slot_q    <= stat.slot;
			len_q     <= stat.len;
			code_q    <= stat.matched ? ent_code : '0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.matched        = matched_q;
	assign result.matched_slot   = slot_q;
	assign result.trigger_length = len_q;
	assign result.end_key        = code_q;

	a_clear_on_match: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> (hist_count == '0))
		else $error("history not cleared after a match");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hist_count) <= HISTORY_DEPTH)
		else $error("history count above depth");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.matched) |->
		(result.matched_slot == '0 && result.trigger_length == '0 && result.end_key == '0))
		else $error("miss result carries nonzero fields");

	a_match_len: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.matched) |->
		(result.trigger_length != '0 && 32'(result.trigger_length) <= TRIG_MAX))
		else $error("matched length out of range");
endmodule

// ===== rtl/tsm_hist.sv =====
module tsm_hist #(
	parameter int HISTORY_DEPTH = 16,
	localparam int HW = $clog2(HISTORY_DEPTH),
	localparam int CW = $clog2(HISTORY_DEPTH + 1)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [tsm_pkg::CHAR_W-1:0] wr_char,
	input  logic                      clr,
	input  logic [HW-1:0]             rd_addr,
	output logic [HW-1:0]             head,
	output logic [CW-1:0]             count,
	output logic [tsm_pkg::CHAR_W-1:0] rd_data
);
	import tsm_pkg::*;

	logic [CHAR_W-1:0] mem_q [HISTORY_DEPTH];
	logic [CHAR_W-1:0] rd_q;
	logic [HW-1:0]     head_q;
	logic [CW-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (wr_en) begin
			head_q <= (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + HW'(1);
			if (count_q != CW'(HISTORY_DEPTH)) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[head_q] <= wr_char;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign head    = head_q;
	assign count   = count_q;
	assign rd_data = rd_q;
endmodule

// ===== rtl/tsm_tbl.sv =====
module tsm_tbl #(
	parameter int NUM_SLOTS = 16,
	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
	localparam int AW = $clog2(NUM_SLOTS * tsm_pkg::TRIG_MAX)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tsm_pkg::tbl_wr_t           wr,
	input  logic [tsm_pkg::SLOT_W-1:0] rd_slot,
	input  logic [tsm_pkg::POS_W-1:0]  rd_pos,
	output logic [tsm_pkg::CHAR_W-1:0] chr_rd,
	output logic [tsm_pkg::LEN_W-1:0]  ent_len,
	output logic [tsm_pkg::CODE_W-1:0] ent_code
);
	import tsm_pkg::*;

	logic [CHAR_W-1:0] mem_q [NUM_SLOTS * TRIG_MAX];
	logic [CHAR_W-1:0] rd_q;
	logic [LEN_W-1:0]  len_q [NUM_SLOTS];
	logic [CODE_W-1:0] code_q [NUM_SLOTS];
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;

	assign wr_addr = AW'({wr.slot, wr.pos});
	assign rd_addr = AW'({rd_slot, rd_pos});

	always_ff @(posedge clk) begin
		if (wr.chr_en) begin
			mem_q[wr_addr] <= wr.chr;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				len_q[i] <= '0;
			end
		end else if (wr.len_en) begin
			len_q[IW'(wr.slot)] <= wr.len;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.len_en) begin
			code_q[IW'(wr.slot)] <= wr.code;
		end
	end

	assign chr_rd   = rd_q;
	assign ent_len  = len_q[IW'(rd_slot)];
	assign ent_code = code_q[IW'(rd_slot)];
endmodule

// ===== rtl/tsm_seq.sv =====
module tsm_seq #(
	parameter int HISTORY_DEPTH = 16,
	parameter int NUM_SLOTS = 16,
	localparam int HW  = $clog2(HISTORY_DEPTH),
	localparam int CW  = $clog2(HISTORY_DEPTH + 1),
	localparam int ECW = $clog2(NUM_SLOTS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       take,
	input  logic [ECW-1:0]             n,
	input  logic [CW-1:0]              count,
	input  logic [HW-1:0]              head,
	input  logic [tsm_pkg::CHAR_W-1:0] hist_rd,
	input  logic [tsm_pkg::CHAR_W-1:0] trig_rd,
	input  logic [tsm_pkg::LEN_W-1:0]  ent_len,
	output logic [HW-1:0]              hist_addr,
	output logic [tsm_pkg::SLOT_W-1:0] rd_slot,
	output logic [tsm_pkg::POS_W-1:0]  rd_pos,
	output tsm_pkg::seq_stat_t         stat
);
	import tsm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [LEN_W-1:0] len_q;
	logic [ECW-1:0]   e_q;
	logic [POS_W-1:0] k_q;
	logic [HW-1:0]    hp_q;
	logic             matched_q;
	logic [LEN_W-1:0] start_len;
	logic [HW:0]      hp_sum;
	logic [HW-1:0]    hp_start;
	logic [HW-1:0]    hp_next;
	logic             chr_eq;

	// longest suffix worth trying is bounded by the trigger size
	assign start_len = (32'(count) > TRIG_MAX) ? LEN_W'(TRIG_MAX) : LEN_W'(count);

	// ring position of the oldest character of the current suffix
	assign hp_sum   = {1'b0, head} + (HW+1)'(HISTORY_DEPTH) - (HW+1)'(len_q);
	assign hp_start = (hp_sum >= (HW+1)'(HISTORY_DEPTH)) ?
		HW'(hp_sum - (HW+1)'(HISTORY_DEPTH)) : HW'(hp_sum);
	assign hp_next  = (hp_q == HW'(HISTORY_DEPTH - 1)) ? '0 : hp_q + HW'(1);

	// shared character comparator
	assign chr_eq = (hist_rd == trig_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			len_q     <= '0;
			e_q       <= '0;
			k_q       <= '0;
			hp_q      <= '0;
			matched_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						len_q     <= start_len;
						e_q       <= '0;
						matched_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (len_q == '0) begin
						state_q <= ST_DONE;
					end else if (e_q == n) begin
						len_q <= len_q - LEN_W'(1);
						e_q   <= '0;
					end else if (ent_len == len_q) begin
						k_q     <= '0;
						hp_q    <= hp_start;
						state_q <= ST_FETCH;
					end else begin
						e_q <= e_q + ECW'(1);
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!chr_eq) begin
						e_q     <= e_q + ECW'(1);
						state_q <= ST_SCAN;
					end else if (k_q == POS_W'(len_q - LEN_W'(1))) begin
						matched_q <= 1'b1;
						state_q   <= ST_DONE;
					end else begin
						k_q     <= k_q + POS_W'(1);
						hp_q    <= hp_next;
						state_q <= ST_FETCH;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign hist_addr    = hp_q;
	assign rd_slot      = SLOT_W'(e_q);
	assign rd_pos       = k_q;
	assign stat.idle    = (state_q == ST_IDLE);
	assign stat.done    = (state_q == ST_DONE);
	assign stat.matched = matched_q;
	assign stat.slot    = matched_q ? SLOT_W'(e_q) : '0;
	assign stat.len     = matched_q ? len_q : '0;
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import tsm_pkg::*;

	localparam int HIST_DEPTH = 16;
	localparam int TABLE_SIZE = 16;
	localparam int ITEM_GOAL  = 1550;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [CHAR_W-1:0] char_code;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  char_pos;
		logic [LEN_W-1:0]  entry_length;
		logic [CODE_W-1:0] new_end_code;
	} req_t;

	typedef struct packed {
		logic              matched;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		logic [CODE_W-1:0] code;
	} match_t;

	localparam int REQ_BITS = $bits(req_t);

	logic clk;
	logic arst_n;

	tsm_item_if item_ch();
	tsm_res_if  res_ch();
	tsm_cfg_if  cfg_ch();

	typed_suffix_trigger_matcher #(
		.HISTORY_DEPTH(HIST_DEPTH),
		.TABLE_ENTRIES(TABLE_SIZE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	logic [CHAR_W-1:0] hist_ring [HIST_DEPTH] = '{default: '0};
	int                hist_head = 0;
	int                hist_fill = 0;
	logic [CHAR_W-1:0] trig_char [TABLE_SIZE][TRIG_MAX] = '{default: '{default: '0}};
	logic [LEN_W-1:0]  trig_len [TABLE_SIZE] = '{default: '0};
	logic [CODE_W-1:0] trig_code [TABLE_SIZE] = '{default: '0};
	logic [LEN_W-1:0]  search_limit = '0;

	match_t match_q[$];

	int fail_cnt      = 0;
	int sent_items    = 0;
	int match_reqs    = 0;
	int hits          = 0;
	int settings_used = 0;
	int idle_odds     = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#120_000_000;
		$display("FAIL typed_suffix_trigger_matcher");
		$finish;
	end

	function automatic match_t search_history();
		match_t hit;
		int     n;
		bit     same;
		hit = '0;
		n = (int'(search_limit) > TABLE_SIZE) ? TABLE_SIZE : int'(search_limit);
		for (int len = hist_fill; len > 0; len--) begin
			for (int e = 0; e < n; e++) begin
				if (int'(trig_len[e]) == len) begin
					same = 1'b1;
					for (int k = 0; k < len; k++)
						if (trig_char[e][k] !=
							hist_ring[(hist_head + HIST_DEPTH - len + k) % HIST_DEPTH])
							same = 1'b0;
					if (same) begin
						hit.matched = 1'b1;
						hit.slot    = SLOT_W'(e);
						hit.len     = LEN_W'(len);
						hit.code    = trig_code[e];
						hist_fill   = 0;
						return hit;
					end
				end
			end
		end
		return hit;
	endfunction

	function automatic void apply_item(req_t r);
		match_t want;
		case (r.req_type)
			REQ_REC: begin
				if (r.char_code != '0) begin
					hist_ring[hist_head] = r.char_code;
					hist_head = (hist_head + 1) % HIST_DEPTH;
					if (hist_fill < HIST_DEPTH)
						hist_fill++;
				end
			end
			REQ_WCHR: trig_char[r.slot][r.char_pos] = r.char_code;
			REQ_WLEN: begin
				trig_len[r.slot]  = r.entry_length;
				trig_code[r.slot] = r.new_end_code;
			end
			default: begin
				want = search_history();
				match_q.push_back(want);
				match_reqs++;
				if (want.matched)
					hits++;
			end
		endcase
	endfunction

	function automatic req_t random_req(logic [REQ_W-1:0] kind);
		req_t r;
		r = req_t'(REQ_BITS'({$urandom, $urandom}));
		r.req_type = kind;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] alpha();
		return CHAR_W'(8'h61 + $urandom_range(0, 3));
	endfunction

	task automatic send_item(req_t r);
		if (idle_odds != 0 && $urandom_range(1, 2 * idle_odds) == 1) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.req_type     <= r.req_type;
		item_ch.char_code    <= r.char_code;
		item_ch.slot         <= r.slot;
		item_ch.char_pos     <= r.char_pos;
		item_ch.entry_length <= r.entry_length;
		item_ch.new_end_code <= r.new_end_code;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		apply_item(r);
		sent_items++;
	endtask

	task automatic type_char(logic [CHAR_W-1:0] ch);
		req_t r;
		r = random_req(REQ_REC);
		r.char_code = ch;
		send_item(r);
	endtask

	task automatic ask_match();
		send_item(random_req(REQ_MATCH));
	endtask

	task automatic put_trig_char(int slot, int pos, logic [CHAR_W-1:0] ch);
		req_t r;
		r = random_req(REQ_WCHR);
		r.slot      = SLOT_W'(slot);
		r.char_pos  = POS_W'(pos);
		r.char_code = ch;
		send_item(r);
	endtask

	task automatic put_entry(int slot, int len, logic [CODE_W-1:0] code);
		req_t r;
		r = random_req(REQ_WLEN);
		r.slot         = SLOT_W'(slot);
		r.entry_length = LEN_W'(len);
		r.new_end_code = code;
		send_item(r);
	endtask

	task automatic program_text(int slot, string text, logic [CODE_W-1:0] code);
		for (int k = 0; k < text.len(); k++)
			put_trig_char(slot, k, text[k]);
		put_entry(slot, text.len(), code);
	endtask

	task automatic reprogram_slot(int slot);
		int len, roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			len = 0;
		else if (roll < 4)
			len = $urandom_range(5, TRIG_MAX);
		else
			len = $urandom_range(1, 4);
		for (int k = 0; k < len; k++)
			put_trig_char(slot, k, alpha());
		if (len < TRIG_MAX && $urandom_range(0, 1) == 1)
			put_trig_char(slot, $urandom_range(len, TRIG_MAX - 1),
				CHAR_W'($urandom_range(0, 255)));
		put_entry(slot, len, CODE_W'($urandom_range(0, 65535)));
	endtask

	task automatic type_trigger(bit broken);
		int live[$];
		int n, e, len, bad, pre;
		logic [CHAR_W-1:0] ch;
		n = (int'(search_limit) > TABLE_SIZE) ? TABLE_SIZE : int'(search_limit);
		for (int s = 0; s < n; s++)
			if (trig_len[s] != '0 && int'(trig_len[s]) <= TRIG_MAX)
				live.push_back(s);
		if (live.size() != 0)
			e = live[$urandom_range(0, live.size() - 1)];
		else
			e = $urandom_range(0, TABLE_SIZE - 1);
		len = (int'(trig_len[e]) > TRIG_MAX) ? TRIG_MAX : int'(trig_len[e]);
		pre = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
		repeat (pre) type_char(alpha());
		bad = $urandom_range(0, (len > 0) ? len - 1 : 0);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 9) == 0)
				type_char('0);
			ch = trig_char[e][k];
			if (broken && k == bad)
				ch = ch ^ 8'h01;
			type_char(ch);
		end
		ask_match();
	endtask

	task automatic set_limit(logic [LEN_W-1:0] value);
		item_ch.valid <= 1'b0;
		while (match_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		search_limit = value;
		settings_used++;
	endtask

	task automatic check_field(string name, logic [CODE_W-1:0] want, logic [CODE_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// result stall bursts
	initial begin
		int stall;
		stall = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall == 0 && idle_odds != 0 && $urandom_range(1, 4 * idle_odds) == 1)
				stall = $urandom_range(1, 16);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				stall--;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		match_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (match_q.size() == 0) begin
				$error("result transaction with no match request pending");
				fail_cnt++;
			end else begin
				want = match_q.pop_front();
				check_field("matched", CODE_W'(want.matched), CODE_W'(res_ch.matched));
				check_field("matched_slot", CODE_W'(want.slot), CODE_W'(res_ch.matched_slot));
				check_field("trigger_length", CODE_W'(want.len),
					CODE_W'(res_ch.trigger_length));
				check_field("end_key", want.code, res_ch.end_key);
			end
		end
	end

	task automatic test_empty_history();
		ask_match();
	endtask

	task automatic test_table_load();
		for (int s = 0; s < TABLE_SIZE; s++)
			for (int p = 0; p < TRIG_MAX; p++)
				put_trig_char(s, p, alpha());
	endtask

	task automatic test_priority_and_specials();
		set_limit(LEN_W'(TABLE_SIZE));
		program_text(0, "ab", 16'hFFFF);
		program_text(1, "b", 16'h0001);
		// longer suffix wins over a shorter one
		type_char("a");
		type_char("b");
		ask_match();
		// zero is dropped from the history
		type_char("b");
		type_char('0);
		ask_match();
		// miss keeps the history
		type_char(8'hFF);
		type_char(8'h80);
		ask_match();
		// zero length and over-long entries never hit
		put_entry(2, 0, 16'h1234);
		put_entry(3, 20, 16'h5678);
		type_char(8'h01);
		ask_match();
	endtask

	task automatic test_entry_limits();
		set_limit('0);
		type_char("b");
		ask_match();
		set_limit(5'd31);
		type_char("b");
		ask_match();
		set_limit(5'd1);
		type_char("b");
		ask_match();
	endtask

	task automatic test_random();
		int phase, pick;
		set_limit(LEN_W'(TABLE_SIZE));
		for (int s = 2; s < TABLE_SIZE; s++)
			reprogram_slot(s);
		phase = 0;
		while (sent_items < ITEM_GOAL) begin
			case (phase % 3)
				0: idle_odds = 0;
				1: idle_odds = 2;
				default: idle_odds = 6;
			endcase
			if (sent_items > ITEM_GOAL - 250)
				idle_odds = 0;
			case (phase % 6)
				0: set_limit(LEN_W'(TABLE_SIZE));
				1: set_limit(5'd1);
				3: set_limit(5'd31);
				4: set_limit(LEN_W'($urandom_range(0, TABLE_SIZE)));
				default: set_limit(LEN_W'($urandom_range(2, TABLE_SIZE - 1)));
			endcase
			repeat (16) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					type_trigger(pick == 5);
				end else if (pick < 8) begin
					reprogram_slot($urandom_range(0, TABLE_SIZE - 1));
				end else begin
					repeat ($urandom_range(1, 6)) begin
						if ($urandom_range(0, 2) != 0)
							type_char(($urandom_range(0, 7) == 0) ? '0 :
								CHAR_W'($urandom_range(0, 255)));
						else
							ask_match();
					end
				end
			end
			phase++;
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		item_ch.valid        <= 1'b0;
		item_ch.req_type     <= REQ_REC;
		item_ch.char_code    <= '0;
		item_ch.slot         <= '0;
		item_ch.char_pos     <= '0;
		item_ch.entry_length <= '0;
		item_ch.new_end_code <= '0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.data          <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_odds = 3;

		test_empty_history();
		test_table_load();
		test_priority_and_specials();
		test_entry_limits();
		test_random();

		idle_odds = 0;
		item_ch.valid <= 1'b0;
		while (match_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d transactions with %0d match requests, %0d of them hits",
			sent_items, match_reqs, hits);
		$display("search limit written %0d times, including 0, 1, 16 and 31", settings_used);
		if (fail_cnt == 0)
			$display("PASS typed_suffix_trigger_matcher");
		else
			$display("FAIL typed_suffix_trigger_matcher");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tsm_pkg.sv
rtl/tsm_if.sv
rtl/tsm_hist.sv
rtl/tsm_tbl.sv
rtl/tsm_seq.sv
rtl/typed_suffix_trigger_matcher.sv
bench/tb_top.sv
